// ===== src/pixel_blend_mode_unit_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pixel blend core.
// ---------------------------------------------------------------------------
`ifndef PIXEL_BLEND_MODE_UNIT_CORE_ASSERT_SVH
`define PIXEL_BLEND_MODE_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel blend assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel blend assertion failed");

`endif

// ===== src/pbm_pkg.sv =====
// ---------------------------------------------------------------------------
// pbm_pkg
// Mode codes and fill codes shared by the pixel blend modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pbm_pkg;

    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned CH_W      = 8;

    typedef enum logic [3:0] {
        MODE_NORMAL     = 4'd0,
        MODE_ADD        = 4'd1,
        MODE_SUBTRACT   = 4'd2,
        MODE_MULTIPLY   = 4'd3,
        MODE_DIVIDE     = 4'd4,
        MODE_SCREEN     = 4'd5,
        MODE_OVERLAY    = 4'd6,
        MODE_DODGE      = 4'd7,
        MODE_BURN       = 4'd8,
        MODE_DIFFERENCE = 4'd9,
        MODE_DARKEN     = 4'd10,
        MODE_LIGHTEN    = 4'd11
    } pbm_mode_t;

    // Whole-pixel override for the degenerate divide, dodge and burn cases.
    typedef enum logic [1:0] {
        FILL_NONE = 2'd0,
        FILL_ZERO = 2'd1,
        FILL_ONES = 2'd2
    } fill_t;

endpackage

`default_nettype wire

// ===== src/pbm_lane.sv =====
// ---------------------------------------------------------------------------
// pbm_lane
// One channel of the blend: operand selection, a registered product with a
// divide-by-255 rounding, and an eight-stage restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none

module pbm_lane (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire pbm_pkg::pbm_mode_t mode,
    input  wire logic [7:0]         b,
    input  wire logic [7:0]         t,
    output logic      [7:0]         o
);

    import pbm_pkg::*;

    localparam int unsigned STEPS = 8;

    typedef enum logic [2:0] {
        K_SIMPLE,
        K_MUL,
        K_SCREEN,
        K_OVL_LO,
        K_OVL_HI,
        K_DIV,
        K_BURN
    } kind_t;

    // Stage 0 values
    kind_t       kind_c;
    logic [7:0]  simple_c;
    logic [7:0]  ma_c, mb_c;
    logic [7:0]  dx_c, dy_c;
    logic [15:0] num_c;
    logic [8:0]  sum_c;

    // Pipeline registers, index is the stage
    logic [15:0] prod_reg;
    logic [7:0]  simple_reg;
    kind_t       kind_reg [STEPS+1];
    logic [7:0]  rem_reg  [STEPS];
    logic [7:0]  lo_reg   [STEPS];
    logic [7:0]  div_reg  [STEPS];
    logic [7:0]  q_reg    [STEPS+1];
    logic        sat_reg  [STEPS+1];
    logic [7:0]  res_reg  [1:STEPS];

    // Divider step and rounding logic
    logic [8:0]  rem2_c [STEPS];
    logic        ge_c   [STEPS];
    logic [7:0]  rem_next [STEPS];
    logic [16:0] rnd_c;
    logic [7:0]  m_c;
    logic [8:0]  m2_c;
    logic [7:0]  res_next;
    logic [7:0]  qv_c;

    always_comb
    begin
        sum_c    = {1'b0, b} + {1'b0, t};
        simple_c = t;
        kind_c   = K_SIMPLE;
        ma_c     = b;
        mb_c     = t;
        dx_c     = b;
        dy_c     = t;
        case (mode)
            MODE_ADD:        simple_c = sum_c[8] ? 8'hFF : sum_c[7:0];
            MODE_SUBTRACT:   simple_c = (b > t) ? b - t : 8'h00;
            MODE_DIFFERENCE: simple_c = (b > t) ? b - t : t - b;
            MODE_DARKEN:     simple_c = (b < t) ? b : t;
            MODE_LIGHTEN:    simple_c = (b > t) ? b : t;
            MODE_MULTIPLY:   kind_c = K_MUL;
            MODE_SCREEN:
            begin
                kind_c = K_SCREEN;
                ma_c   = ~b;
                mb_c   = ~t;
            end
            MODE_OVERLAY:
            begin
                if (b[7])
                begin
                    kind_c = K_OVL_HI;
                    ma_c   = ~b;
                    mb_c   = ~t;
                end
                else
                begin
                    kind_c = K_OVL_LO;
                end
            end
            MODE_DIVIDE:     kind_c = K_DIV;
            MODE_DODGE:
            begin
                kind_c = K_DIV;
                dy_c   = ~t;
            end
            MODE_BURN:
            begin
                kind_c = K_BURN;
                dx_c   = ~b;
            end
            default:         simple_c = t;
        endcase
        // x*255 as a shift and subtract.
        num_c = {dx_c, 8'h00} - {8'h00, dx_c};
    end

    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            rem2_c[k]   = {rem_reg[k], lo_reg[k][7]};
            ge_c[k]     = (rem2_c[k] >= {1'b0, div_reg[k]});
            rem_next[k] = ge_c[k] ? 8'(rem2_c[k] - {1'b0, div_reg[k]}) : rem2_c[k][7:0];
        end
        // floor(p/255) for p below 65280.
        rnd_c = {1'b0, prod_reg} + {9'h000, prod_reg[15:8]} + 17'd1;
        m_c   = rnd_c[15:8];
        m2_c  = {m_c, 1'b0};
        case (kind_reg[0])
            K_MUL:    res_next = m_c;
            K_SCREEN: res_next = ~m_c;
            K_OVL_LO: res_next = m2_c[8] ? 8'hFF : m2_c[7:0];
            K_OVL_HI: res_next = m2_c[8] ? 8'h00 : ~m2_c[7:0];
            default:  res_next = simple_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= ({8'h00, ma_c} * {8'h00, mb_c}) + 16'd127;
            simple_reg  <= simple_c;
            kind_reg[0] <= kind_c;
            rem_reg[0]  <= num_c[15:8];
            lo_reg[0]   <= num_c[7:0];
            div_reg[0]  <= dy_c;
            q_reg[0]    <= 8'h00;
            // A zero divisor also lands here and gives 255.
            sat_reg[0]  <= (dx_c >= dy_c);
            res_reg[1]  <= res_next;
            for (int k = 0; k < STEPS; k++)
            begin
                kind_reg[k+1] <= kind_reg[k];
                q_reg[k+1]    <= {q_reg[k][6:0], ge_c[k]};
                sat_reg[k+1]  <= sat_reg[k];
            end
            for (int k = 0; k < STEPS-1; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                lo_reg[k+1]   <= {lo_reg[k][6:0], 1'b0};
                div_reg[k+1]  <= div_reg[k];
            end
            for (int k = 1; k < STEPS; k++)
            begin
                res_reg[k+1] <= res_reg[k];
            end
        end
    end

    always_comb
    begin
        qv_c = sat_reg[STEPS] ? 8'hFF : q_reg[STEPS];
        case (kind_reg[STEPS])
            K_DIV:   o = qv_c;
            K_BURN:  o = ~qv_c;
            default: o = res_reg[STEPS];
        endcase
    end

endmodule

`default_nettype wire

// ===== src/pbm_merge.sv =====
// ---------------------------------------------------------------------------
// pbm_merge
// Combines the four lane results into one pixel, applying the whole-pixel
// fill of the degenerate divide, dodge and burn cases.
// ---------------------------------------------------------------------------
`default_nettype none

module pbm_merge (
    input  wire pbm_pkg::fill_t fill,
    input  wire logic [7:0]     lane_out [pbm_pkg::NUM_LANES],
    output logic      [31:0]    tdata
);

    import pbm_pkg::*;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            case (fill)
                FILL_ZERO: tdata[8*i +: 8] = 8'h00;
                FILL_ONES: tdata[8*i +: 8] = 8'hFF;
                default:   tdata[8*i +: 8] = lane_out[i];
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/pixel_blend_mode_unit_core.sv =====
// ---------------------------------------------------------------------------
// pixel_blend_mode_unit_core
// Separable blend of a bottom and a top ARGB pixel, one lane per channel.
// ---------------------------------------------------------------------------
//  channel    dir   payload
//  s_axis     in    s_tdata: two ARGB pixels, 64 bits
//  m_axis     out   m_tdata: blended ARGB pixel, 32 bits
//  mode       in    mode_wr_en / mode_wr_data, 4 bits
//
// One item is accepted per cycle while the output is not stalled; the pipeline
// depth is set by the eight-stage quotient divider in every lane.
// Reset clears the stage valid bits and sets the mode to normal.
// A stalled output holds the whole pipeline, so s_tready falls with it.
// ---------------------------------------------------------------------------
`default_nettype none

module pixel_blend_mode_unit_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        mode_wr_en,
    input  wire logic [3:0]  mode_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // bottom_alpha, bottom_red, bottom_green, bottom_blue,
    // top_alpha, top_red, top_green, top_blue (lowest bits first)
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_alpha, out_red, out_green, out_blue (lowest bits first)
    output logic      [31:0] m_tdata
);

    import pbm_pkg::*;

    `include "pixel_blend_mode_unit_core_assert.svh"

    localparam int unsigned DEPTH = 10;

    pbm_mode_t   mode_reg;
    logic [DEPTH-1:0] vld_reg;
    fill_t       fill_reg [DEPTH-1];
    fill_t       fill_c;
    logic        en;
    logic        top_black, top_white;
    logic [7:0]  lane_out [NUM_LANES];
    logic [31:0] merged;
    logic [31:0] m_tdata_reg;

    assign en       = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[DEPTH-1];
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
        end
        else if (mode_wr_en)
        begin
            mode_reg <= pbm_mode_t'(mode_wr_data);
        end
    end

    always_comb
    begin
        top_black = (s_tdata[47:40] == 8'h00) && (s_tdata[55:48] == 8'h00)
                    && (s_tdata[63:56] == 8'h00);
        top_white = (s_tdata[47:40] == 8'hFF) && (s_tdata[55:48] == 8'hFF)
                    && (s_tdata[63:56] == 8'hFF);
        fill_c = FILL_NONE;
        if ((mode_reg == MODE_DIVIDE) && top_black)
        begin
            fill_c = FILL_ZERO;
        end
        else if ((mode_reg == MODE_DODGE) && top_white)
        begin
            fill_c = FILL_ZERO;
        end
        else if ((mode_reg == MODE_BURN) && top_black)
        begin
            fill_c = FILL_ONES;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fill_reg[0] <= fill_c;
            for (int k = 1; k < DEPTH-1; k++)
            begin
                fill_reg[k] <= fill_reg[k-1];
            end
            m_tdata_reg <= merged;
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        pbm_lane u_lane (
            .clk  (clk),
            .en   (en),
            .mode (mode_reg),
            .b    (s_tdata[8*i +: 8]),
            .t    (s_tdata[32 + 8*i +: 8]),
            .o    (lane_out[i])
        );
    end

    pbm_merge u_merge (
        .fill     (fill_reg[DEPTH-2]),
        .lane_out (lane_out),
        .tdata    (merged)
    );

    `PBM_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
    `PBM_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0])
    `PBM_ASSERT_NEXT(a_hold_when_stalled, !en, $stable(vld_reg))

endmodule

`default_nettype wire
